@@ hw/rtl/id_allocator_free_queue_unit_defines.svh @@
// ----------------------------------------------------------------------------
// id allocator free queue unit assertion macros
// shared assertion helpers for the identifier allocator rtl
// ----------------------------------------------------------------------------
`ifndef ID_ALLOCATOR_FREE_QUEUE_UNIT_DEFINES_SVH
`define ID_ALLOCATOR_FREE_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check under reset disable
`define IAFQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("iafq assertion failed");
// check at every edge, reset included
`define IAFQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("iafq assertion failed");
`else
`define IAFQ_ASSERT(lbl, clk, rst_n, prop)
`define IAFQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ hw/rtl/iafq_pkg.sv @@
// ----------------------------------------------------------------------------
// iafq package
// defaults, command and status codes for the identifier allocator
// ----------------------------------------------------------------------------
`default_nettype none

package iafq_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int ID_WIDTH_DEF    = 16;

    typedef enum logic {
        CMD_ALLOCATE = 1'b0,
        CMD_RELEASE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EXHAUSTED = 2'd2
    } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/id_allocator_free_queue_unit.sv @@
// ----------------------------------------------------------------------------
// id allocator free queue unit
// hands out identifiers from a free queue or a high-water counter
// ----------------------------------------------------------------------------
// usage:
//   slave channel s_*: one request per transfer. s_tuser is the command
//   (allocate or release), s_tdata carries the identifier given back.
//   master channel m_*: exactly one result per request, in request order.
//   m_tdata is the granted identifier (zero unless an allocate succeeded),
//   m_tuser the status: done, queue full (release dropped) or exhausted.
// result path: a result is registered in the output register; an allocate
//   served from the free queue first passes through the registered read
//   port of the queue memory and the read state.
// throughput: one request per cycle while the output is not stalled,
//   except that an allocate served from the queue holds the slave side
//   while the read of the queue memory returns.
// reset: pointers, count and high-water counter clear at once; the queue
//   memory needs no clearing, only written entries are ever read.
// stall: a result waits in the output register; a new request is taken
//   in the same cycle the waiting result is transferred out.
// ----------------------------------------------------------------------------
`default_nettype none
`include "id_allocator_free_queue_unit_defines.svh"

module id_allocator_free_queue_unit #(
    parameter int QUEUE_DEPTH = iafq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = iafq_pkg::ID_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [ID_WIDTH-1:0] release_id, rest zero
    input  wire logic [((ID_WIDTH + 7) / 8) * 8-1:0] s_tdata,
    // [0] cmd
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [ID_WIDTH-1:0] granted_id, rest zero
    output logic [((ID_WIDTH + 7) / 8) * 8-1:0]      m_tdata,
    // [1:0] status
    output logic [1:0]                              m_tuser
);

    localparam int TDW   = ((ID_WIDTH + 7) / 8) * 8;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ID_WIDTH:0]     fresh_reg, fresh_next;
    logic                  m_valid_reg, m_valid_next;
    logic [ID_WIDTH-1:0]   granted_reg, granted_next;
    iafq_pkg::status_t     status_reg, status_next;

    logic [ID_WIDTH-1:0]   queue_mem [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]   rd_data_reg;

    logic                  accept;
    logic                  is_release;
    logic [ID_WIDTH-1:0]   release_id;
    logic [ID_WIDTH:0]     fresh_dec;
    logic                  rel_match;
    logic                  q_full;
    logic                  q_empty;
    logic [PTR_W-1:0]      head_inc;
    logic [PTR_W-1:0]      tail_inc;
    logic                  mem_we;

    assign s_tready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign is_release = (iafq_pkg::cmd_t'(s_tuser) == iafq_pkg::CMD_RELEASE);
    assign release_id = s_tdata[ID_WIDTH-1:0];
    assign fresh_dec  = fresh_reg - 1'b1;
    // only the identifier just below the counter winds the counter back
    assign rel_match  = (fresh_reg != '0) && ({1'b0, release_id} == fresh_dec);
    assign q_full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty    = (count_reg == '0);
    assign head_inc   = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign mem_we     = accept && is_release && !rel_match && !q_full;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDW'(granted_reg);
    assign m_tuser  = status_reg;

    // queue memory, registered read at the head pointer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            queue_mem[tail_reg] <= release_id;
        end
        rd_data_reg <= queue_mem[head_reg];
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        m_valid_next = m_valid_reg && !m_tready;
        granted_next = granted_reg;
        status_next  = status_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!is_release) begin
                        if (!q_empty) begin
                            // result follows once the read returns
                            state_next = ST_READ;
                            head_next  = head_inc;
                            count_next = count_reg - 1'b1;
                        end else if (fresh_reg[ID_WIDTH]) begin
                            m_valid_next = 1'b1;
                            granted_next = '0;
                            status_next  = iafq_pkg::STATUS_EXHAUSTED;
                        end else begin
                            m_valid_next = 1'b1;
                            granted_next = fresh_reg[ID_WIDTH-1:0];
                            status_next  = iafq_pkg::STATUS_DONE;
                            fresh_next   = fresh_reg + 1'b1;
                        end
                    end else begin
                        m_valid_next = 1'b1;
                        granted_next = '0;
                        if (rel_match) begin
                            fresh_next  = fresh_dec;
                            status_next = iafq_pkg::STATUS_DONE;
                        end else if (q_full) begin
                            status_next = iafq_pkg::STATUS_FULL;
                        end else begin
                            tail_next   = tail_inc;
                            count_next  = count_reg + 1'b1;
                            status_next = iafq_pkg::STATUS_DONE;
                        end
                    end
                end
            end
            ST_READ: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
                granted_next = rd_data_reg;
                status_next  = iafq_pkg::STATUS_DONE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            fresh_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    `IAFQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH))
    `IAFQ_ASSERT(a_fresh_bound, aclk, aresetn, fresh_reg <= ((ID_WIDTH + 1)'(1) << ID_WIDTH))
    `IAFQ_ASSERT(a_ring_consistent, aclk, aresetn, (q_empty || q_full) |-> (head_reg == tail_reg))
    `IAFQ_ASSERT(a_read_slot_free, aclk, aresetn, (state_reg == ST_READ) |-> !m_valid_reg)
    `IAFQ_ASSERT(a_read_follows_alloc, aclk, aresetn, (state_reg == ST_READ) |-> $past(accept && !is_release))

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// identifier allocator free queue testbench
// drives allocate and release requests with random idling on both channels,
// predicts every granted identifier and status, and checks the results in
// order; ends with a short stretch without idling on either side
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QDEPTH    = iafq_pkg::QUEUE_DEPTH_DEF;
    localparam int          ID_W      = iafq_pkg::ID_WIDTH_DEF;
    localparam int          DATA_W    = ((ID_W + 7) / 8) * 8;
    localparam int unsigned ID_SPAN   = 1 << ID_W;
    localparam int          RANDOM_N  = 1700;
    localparam int          CALM_N    = 60;
    localparam int          LIMIT     = 600000;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        iafq_pkg::status_t status;
    } grant_t;

    typedef enum {
        MIX_TRACKED,
        RELEASE_FLOOD,
        ALLOC_HEAVY,
        NOISE
    } episode_t;

    // mirror of the allocator state plus the results still owed by the block
    class id_pool_tracker;
        logic [ID_W-1:0] freed_ids[$];
        logic [ID_W:0]   high_water;
        grant_t          owed[$];
        int              faults;

        function new();
            high_water = '0;
            faults     = 0;
        endfunction

        function grant_t take_request(iafq_pkg::cmd_t cmd, logic [ID_W-1:0] id);
            grant_t g;
            g.id     = '0;
            g.status = iafq_pkg::STATUS_DONE;
            if (cmd == iafq_pkg::CMD_ALLOCATE) begin
                if (freed_ids.size() > 0) begin
                    g.id = freed_ids.pop_front();
                end else if (high_water == ID_SPAN) begin
                    g.status = iafq_pkg::STATUS_EXHAUSTED;
                end else begin
                    g.id = high_water[ID_W-1:0];
                    high_water++;
                end
            end else if (high_water != 0 && {1'b0, id} == high_water - 1'b1) begin
                // giving back the top identifier just lowers the counter
                high_water--;
            end else if (freed_ids.size() >= QDEPTH) begin
                g.status = iafq_pkg::STATUS_FULL;
            end else begin
                freed_ids.push_back(id);
            end
            owed.push_back(g);
            return g;
        endfunction

        function void match_grant(logic [DATA_W-1:0] data, logic [1:0] user);
            grant_t g;
            if (owed.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: id %h status %0d", data, user);
                return;
            end
            g = owed.pop_front();
            if (data !== DATA_W'(g.id) || user !== g.status) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: expected id %h status %0d, got id %h status %0d",
                             g.id, g.status, data, user);
            end
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;

    id_pool_tracker  pool = new();
    logic [ID_W-1:0] held_ids[$];
    bit              gaps_on  = 1'b0;
    bit              stall_on = 1'b0;
    bit              calm     = 1'b0;
    int              cycles   = 0;

    id_allocator_free_queue_unit #(
        .QUEUE_DEPTH(QDEPTH),
        .ID_WIDTH   (ID_W)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            pool.match_grant(m_tdata, m_tuser);
    end

    // receiver back-pressure in bursts
    initial begin
        wait (aresetn === 1'b1);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (stall_on && !calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send(input iafq_pkg::cmd_t cmd, input logic [ID_W-1:0] id);
        grant_t g;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= DATA_W'(id);
        do @(posedge aclk); while (!s_tready);
        g = pool.take_request(cmd, id);
        if (cmd == iafq_pkg::CMD_ALLOCATE && g.status == iafq_pkg::STATUS_DONE && !calm)
            held_ids.push_back(g.id);
        if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pool.owed.size() != 0);
    endtask

    // mostly identifiers that are really out, sometimes the top one
    task automatic pick_release(output logic [ID_W-1:0] id);
        int r;
        int k;
        r = $urandom_range(0, 9);
        if (r < 4 && pool.high_water != 0) begin
            id = ID_W'(pool.high_water - 1'b1);
        end else if (r < 9 && held_ids.size() != 0) begin
            k  = $urandom_range(0, held_ids.size() - 1);
            id = held_ids[k];
            held_ids.delete(k);
        end else begin
            id = ID_W'($urandom);
        end
    endtask

    initial begin
        int              sent;
        int              len;
        episode_t        kind;
        iafq_pkg::cmd_t  cmd;
        logic [ID_W-1:0] id;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening: counter climbs and falls back to zero
        send(iafq_pkg::CMD_ALLOCATE, 16'hFFFF);
        send(iafq_pkg::CMD_ALLOCATE, 16'h0000);
        send(iafq_pkg::CMD_RELEASE,  16'h0001);
        send(iafq_pkg::CMD_RELEASE,  16'h0000);
        // release at counter zero and above the counter go to the queue
        send(iafq_pkg::CMD_RELEASE,  16'h0000);
        send(iafq_pkg::CMD_RELEASE,  16'hFFFF);
        send(iafq_pkg::CMD_ALLOCATE, 16'h0000);
        send(iafq_pkg::CMD_ALLOCATE, 16'h0000);
        send(iafq_pkg::CMD_ALLOCATE, 16'h0000);
        send(iafq_pkg::CMD_RELEASE,  16'h0005);
        send(iafq_pkg::CMD_RELEASE,  16'h0000);
        send(iafq_pkg::CMD_ALLOCATE, 16'h1234);
        send(iafq_pkg::CMD_RELEASE,  16'hAAAA);
        send(iafq_pkg::CMD_RELEASE,  16'h5555);
        send(iafq_pkg::CMD_ALLOCATE, 16'h0000);
        send(iafq_pkg::CMD_ALLOCATE, 16'h0000);
        send(iafq_pkg::CMD_ALLOCATE, 16'h0000);
        send(iafq_pkg::CMD_ALLOCATE, 16'h0000);
        // below the counter but not the top one
        send(iafq_pkg::CMD_RELEASE,  16'h0000);
        send(iafq_pkg::CMD_ALLOCATE, 16'h0000);
        drain();

        sent = 0;
        while (sent < RANDOM_N) begin
            // the first episode fills the queue past its depth
            if (sent == 0) begin
                kind = RELEASE_FLOOD;
                len  = 140;
            end else begin
                kind = episode_t'($urandom_range(0, 3));
                len  = $urandom_range(10, 120);
            end
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            repeat (len) begin
                id = ID_W'($urandom);
                case (kind)
                    RELEASE_FLOOD: begin
                        cmd = iafq_pkg::CMD_RELEASE;
                    end
                    ALLOC_HEAVY: begin
                        cmd = ($urandom_range(0, 4) != 0) ? iafq_pkg::CMD_ALLOCATE
                                                          : iafq_pkg::CMD_RELEASE;
                        if (cmd == iafq_pkg::CMD_RELEASE) pick_release(id);
                    end
                    MIX_TRACKED: begin
                        cmd = iafq_pkg::cmd_t'($urandom_range(0, 1));
                        if (cmd == iafq_pkg::CMD_RELEASE) pick_release(id);
                    end
                    default: begin
                        cmd = iafq_pkg::cmd_t'($urandom_range(0, 1));
                    end
                endcase
                send(cmd, id);
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                drain();
        end

        // closing stretch without idling on either side
        calm = 1'b1;
        drain();
        repeat (CALM_N) begin
            cmd = iafq_pkg::cmd_t'($urandom_range(0, 1));
            id  = ID_W'($urandom);
            if (cmd == iafq_pkg::CMD_RELEASE) pick_release(id);
            send(cmd, id);
        end
        drain();
        repeat (8) @(posedge aclk);

        if (pool.faults == 0 && pool.owed.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/iafq_pkg.sv
hw/rtl/id_allocator_free_queue_unit.sv
tb/tb_top.sv
